// File: sv/scle_pkg.sv
// ----------------------------------------------------------------------------
// scle_pkg
// Shared types, constants and command table of the serial command line editor.
// ----------------------------------------------------------------------------
package scle_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 64;
  localparam int unsigned FILL_W         = 8;
  localparam int unsigned NUM_CMDS       = 7;
  localparam int unsigned CMD_MAX        = 22;
  localparam int unsigned CMD_BITS       = CMD_MAX * 8;
  localparam int unsigned CMD_IDX_W      = 3;
  localparam int unsigned CMD_POS_W      = 5;
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned Q_PTR_W        = 1;

  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_LOW  = 8'h20;
  localparam logic [7:0] CH_HIGH = 8'h7E;

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_ERASE,
    OP_NEWLINE
  } op_e;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_CMD     = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           tx_byte;
    logic [CMD_IDX_W-1:0] command_index;
    logic [CMD_POS_W-1:0] argument_start;
    logic [FILL_W-1:0]    line_length;
    logic                 last;
  } res_t;

  // strings right-justified: last character in the low byte
  localparam logic [CMD_BITS-1:0] CMD_TEXT [NUM_CMDS] = '{
    CMD_BITS'("ping"),
    CMD_BITS'("reset"),
    CMD_BITS'("write wifi passphrase "),
    CMD_BITS'("write wifi ssid "),
    CMD_BITS'("get ip"),
    CMD_BITS'("get status"),
    CMD_BITS'("help")
  };

  localparam logic [CMD_POS_W-1:0] CMD_LEN [NUM_CMDS] = '{
    5'd4, 5'd5, 5'd22, 5'd16, 5'd6, 5'd10, 5'd4
  };

  function automatic logic [CMD_POS_W-1:0] cmd_len(input logic [CMD_IDX_W-1:0] idx);
    return CMD_LEN[idx];
  endfunction

  function automatic logic [7:0] cmd_char(input logic [CMD_IDX_W-1:0] idx,
                                          input logic [CMD_POS_W-1:0] pos);
    logic [CMD_POS_W-1:0] sel;
    sel = CMD_LEN[idx] - pos - 5'd1;
    return CMD_TEXT[idx][sel*8 +: 8];
  endfunction

endpackage

// File: sv/serial_command_line_editor.sv
// ----------------------------------------------------------------------------
// serial_command_line_editor
// Line editor for a serial console with command prefix matching.
// ----------------------------------------------------------------------------
// usage
//   slave stream: one received byte per beat in s_axis_tdata
//   master stream: echo bytes (tuser echo) and, after a non-empty line,
//   one command report (tuser recognized or unknown); tlast marks the final
//   beat caused by one received byte
//   a printable byte echoes through the queue and the output register; erase
//   gives three beats; a line feed gives its echo, then the report after
//   matching, one stored character read per cycle from the line store
//   against the command table
//   dropped bytes give no beats
//   a two-entry operation queue sits between the byte classifier and the
//   line engine, so input beats keep being taken while a result waits
//   when the receiver holds m_axis_tready low the engine stops at its output
//   register and the queue fills, then s_axis_tready falls
//   reset empties the line, the queue and the output register
// ----------------------------------------------------------------------------
module serial_command_line_editor import scle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // tx_byte[7:0], command_index[10:8],
                                      // argument_start[15:11], line_length[23:16]
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast    // last
);

  logic q_full;
  logic q_push;
  op_t  q_push_op;
  logic q_pop;
  op_t  q_pop_op;
  logic q_empty;
  res_t res;

  scle_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_op_o        (q_push_op)
  );

  scle_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .pop_op_o  (q_pop_op),
    .empty_o   (q_empty)
  );

  scle_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_op_i      (q_pop_op),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.line_length, res.argument_start, res.command_index, res.tx_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// File: sv/scle_front.sv
// ----------------------------------------------------------------------------
// scle_front
// Takes received bytes, sorts them into print, erase and newline operations
// and pushes those into the operation queue; all other bytes are dropped.
// ----------------------------------------------------------------------------
module scle_front import scle_pkg::*; (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // rx_byte[7:0]
  input  logic       q_full_i,
  output logic       q_push_o,
  output op_t        q_op_o
);

  logic keep;

  always_comb begin
    keep         = 1'b1;
    q_op_o.data  = s_axis_tdata;
    q_op_o.op    = OP_PRINT;
    if (s_axis_tdata == CH_LF) begin
      q_op_o.op = OP_NEWLINE;
    end else if (s_axis_tdata == CH_BS || s_axis_tdata == CH_DEL) begin
      q_op_o.op = OP_ERASE;
    end else if (s_axis_tdata < CH_LOW || s_axis_tdata > CH_HIGH) begin
      keep = 1'b0;
    end
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && keep;

endmodule

// File: sv/scle_fifo.sv
// ----------------------------------------------------------------------------
// scle_fifo
// Short operation queue between the byte classifier and the line engine.
// ----------------------------------------------------------------------------
module scle_fifo import scle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  pop_op_o,
  output logic empty_o
);

  op_t                entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q;
  logic [Q_PTR_W-1:0] rd_ptr_q;
  logic [Q_PTR_W:0]   count_q;

  assign full_o   = count_q == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty_o  = count_q == '0;
  assign pop_op_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/scle_back.sv
// ----------------------------------------------------------------------------
// scle_back
// Line engine: holds the line store and fill count, emits echo and report beats
// and matches a finished line against the command table one character a cycle.
// ----------------------------------------------------------------------------
module scle_back import scle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  op_t  q_op_i,
  output logic q_pop_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERASE_SP,
    ST_ERASE_BS,
    ST_MATCH_CHK,
    ST_MATCH_CMP,
    ST_REPORT
  } state_e;

  state_e               state_q;
  logic [FILL_W-1:0]    fill_q;
  logic [CMD_IDX_W-1:0] cmd_q;
  logic [CMD_POS_W-1:0] pos_q;
  logic                 hit_q;
  logic                 out_valid_q;
  res_t                 out_q;

  logic [7:0]    line_mem [LINE_DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] raddr;
  logic          can_load;
  logic          room;
  logic          wr_en;
  logic          out_load;

  assign can_load = !out_valid_q || res_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i && can_load;
  assign room     = ({1'b0, fill_q} + 9'd1) < 9'(LINE_DEPTH);
  assign wr_en    = q_pop_o && (q_op_i.op == OP_PRINT) && room;
  assign raddr    = (state_q == ST_MATCH_CMP) ? AW'(pos_q + 5'd1) : '0;

  always_comb begin
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        out_load = q_pop_o && (((q_op_i.op == OP_PRINT) && room) ||
                               ((q_op_i.op == OP_ERASE) && (fill_q != '0)) ||
                               (q_op_i.op == OP_NEWLINE));
      end
      ST_ERASE_SP, ST_ERASE_BS, ST_REPORT: begin
        out_load = can_load;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[fill_q[AW-1:0]] <= q_op_i.data;
    end
    rdata_q <= line_mem[raddr];
  end

  function automatic res_t echo(input logic [7:0] b, input logic lst);
    res_t r;
    r         = '0;
    r.kind    = KIND_ECHO;
    r.tx_byte = b;
    r.last    = lst;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cmd_q       <= '0;
      pos_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            unique case (q_op_i.op)
              OP_PRINT: begin
                if (room) begin
                  out_q  <= echo(q_op_i.data, 1'b1);
                  fill_q <= fill_q + 1'b1;
                end
              end
              OP_ERASE: begin
                if (fill_q != '0) begin
                  out_q   <= echo(CH_BS, 1'b0);
                  fill_q  <= fill_q - 1'b1;
                  state_q <= ST_ERASE_SP;
                end
              end
              OP_NEWLINE: begin
                out_q <= echo(CH_LF, fill_q == '0);
                if (fill_q != '0) begin
                  cmd_q   <= '0;
                  state_q <= ST_MATCH_CHK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ERASE_SP: begin
          if (can_load) begin
            out_q   <= echo(CH_SP, 1'b0);
            state_q <= ST_ERASE_BS;
          end
        end
        ST_ERASE_BS: begin
          if (can_load) begin
            out_q   <= echo(CH_BS, 1'b1);
            state_q <= ST_IDLE;
          end
        end
        ST_MATCH_CHK: begin
          if (fill_q < FILL_W'(cmd_len(cmd_q))) begin
            if (cmd_q == CMD_IDX_W'(NUM_CMDS - 1)) begin
              hit_q   <= 1'b0;
              state_q <= ST_REPORT;
            end else begin
              cmd_q <= cmd_q + 1'b1;
            end
          end else begin
            pos_q   <= '0;
            state_q <= ST_MATCH_CMP;
          end
        end
        ST_MATCH_CMP: begin
          if (rdata_q == cmd_char(cmd_q, pos_q)) begin
            if (pos_q + 5'd1 == cmd_len(cmd_q)) begin
              hit_q   <= 1'b1;
              state_q <= ST_REPORT;
            end else begin
              pos_q <= pos_q + 5'd1;
            end
          end else if (cmd_q == CMD_IDX_W'(NUM_CMDS - 1)) begin
            hit_q   <= 1'b0;
            state_q <= ST_REPORT;
          end else begin
            cmd_q   <= cmd_q + 1'b1;
            state_q <= ST_MATCH_CHK;
          end
        end
        ST_REPORT: begin
          if (can_load) begin
            out_q.tx_byte     <= '0;
            out_q.line_length <= fill_q;
            out_q.last        <= 1'b1;
            if (hit_q) begin
              out_q.kind           <= KIND_CMD;
              out_q.command_index  <= cmd_q;
              out_q.argument_start <= cmd_len(cmd_q);
            end else begin
              out_q.kind           <= KIND_UNKNOWN;
              out_q.command_index  <= '0;
              out_q.argument_start <= '0;
            end
            fill_q  <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// File: verif/serial_command_line_editor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_command_line_editor_tb
// Feeds received bytes into the line editor and checks every output beat
// against an in-bench model of the line buffer and the command table:
// directed control bytes and short lines first, then random command lines,
// junk lines, noise bytes and one overfilled line, with random idling on
// both streams, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module serial_command_line_editor_tb import scle_pkg::*;;

  localparam int unsigned DEPTH = LINE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  serial_command_line_editor #(
    .LINE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  string cmd_text [NUM_CMDS] = '{
    "ping", "reset", "write wifi passphrase ", "write wifi ssid ",
    "get ip", "get status", "help"
  };

  logic [7:0]  rx_bytes_q [$];
  res_t        reply_q [$];
  logic [7:0]  line_buf [DEPTH];
  int unsigned line_fill = 0;
  int          rx_cnt = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          in_fire = 1'b0;
  res_t        seen;
  res_t        want;
  logic        calm;

  // no idling on either side over this stretch of input beats
  assign calm = (rx_cnt >= 150) && (rx_cnt < 230);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit line_starts_with(string s);
    if (line_fill < s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (line_buf[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_replies(input logic [7:0] b);
    res_t r [$];
    res_t e;
    int   hit;
    e = '0;
    if (b == CH_LF) begin
      e.kind = KIND_ECHO;
      e.tx_byte = CH_LF;
      r.push_back(e);
      if (line_fill > 0) begin
        hit = -1;
        for (int c = 0; c < NUM_CMDS; c++) begin
          if (hit < 0 && line_starts_with(cmd_text[c])) hit = c;
        end
        e = '0;
        if (hit >= 0) begin
          e.kind = KIND_CMD;
          e.command_index = CMD_IDX_W'(hit);
          e.argument_start = CMD_POS_W'(cmd_text[hit].len());
        end else begin
          e.kind = KIND_UNKNOWN;
        end
        e.line_length = FILL_W'(line_fill);
        r.push_back(e);
      end
      line_fill = 0;
    end else if (b == CH_BS || b == CH_DEL) begin
      if (line_fill > 0) begin
        e.kind = KIND_ECHO;
        e.tx_byte = CH_BS;
        r.push_back(e);
        e.tx_byte = CH_SP;
        r.push_back(e);
        e.tx_byte = CH_BS;
        r.push_back(e);
        line_fill--;
      end
    end else if (line_fill + 1 < DEPTH && b >= CH_LOW && b <= CH_HIGH) begin
      line_buf[line_fill] = b;
      line_fill++;
      e.kind = KIND_ECHO;
      e.tx_byte = b;
      r.push_back(e);
    end
    if (r.size() > 0) r[r.size()-1].last = 1'b1;
    foreach (r[i]) reply_q.push_back(r[i]);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_bytes_q.push_back(s[i]);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (rx_bytes_q.size() > 0 && (calm || $urandom_range(0, 99) >= 8)) begin
        s_axis_tdata  <= rx_bytes_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && rx_cnt >= 80) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // input beat prediction and output beat check
  always @(posedge clk_i) begin
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      predict_replies(s_axis_tdata);
      rx_cnt++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind           = kind_e'(m_axis_tuser);
      seen.tx_byte        = m_axis_tdata[7:0];
      seen.command_index  = m_axis_tdata[10:8];
      seen.argument_start = m_axis_tdata[15:11];
      seen.line_length    = m_axis_tdata[23:16];
      seen.last           = m_axis_tlast;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected beat kind %0d tx %h idx %0d arg %0d len %0d last %0d",
                 $time, seen.kind, seen.tx_byte, seen.command_index,
                 seen.argument_start, seen.line_length, seen.last);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        if (seen !== want) begin
          $display("%0t: expected kind %0d tx %h idx %0d arg %0d len %0d last %0d",
                   $time, want.kind, want.tx_byte, want.command_index,
                   want.argument_start, want.line_length, want.last);
          $display("%0t: actual   kind %0d tx %h idx %0d arg %0d len %0d last %0d",
                   $time, seen.kind, seen.tx_byte, seen.command_index,
                   seen.argument_start, seen.line_length, seen.last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int          c;
    int          n;
    string       s;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // control bytes, erase and newline on an empty line, dropped bytes
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(8'h80);
    rx_bytes_q.push_back(CH_DEL);
    rx_bytes_q.push_back(CH_BS);
    rx_bytes_q.push_back(CH_LF);
    rx_bytes_q.push_back(8'h0D);
    rx_bytes_q.push_back(8'h1F);
    // line shorter than the command
    push_text("pin");
    rx_bytes_q.push_back(CH_LF);
    // printable extremes and both erase bytes
    rx_bytes_q.push_back(CH_LOW);
    rx_bytes_q.push_back(CH_HIGH);
    push_text("x");
    rx_bytes_q.push_back(CH_DEL);
    rx_bytes_q.push_back(CH_BS);
    rx_bytes_q.push_back(CH_LF);
    push_text("help");
    rx_bytes_q.push_back(CH_LF);

    // drain pause: everything accepted and every reply seen
    do @(posedge clk_i);
    while (rx_bytes_q.size() > 0 || s_axis_tvalid || reply_q.size() > 0);
    repeat (100) @(posedge clk_i);

    // overfilled line, erase at full and refill
    push_text("get status ");
    for (int i = 0; i < 60; i++) rx_bytes_q.push_back(8'($urandom_range(CH_LOW, CH_HIGH)));
    rx_bytes_q.push_back(CH_BS);
    push_text("z");
    rx_bytes_q.push_back(CH_LF);

    while (rx_bytes_q.size() < 245) begin
      c = $urandom_range(0, 99);
      if (c < 70) begin
        s = cmd_text[$urandom_range(0, NUM_CMDS-1)];
        if ($urandom_range(0, 4) == 0) s = s.substr(0, $urandom_range(0, s.len() - 2));
        push_text(s);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          rx_bytes_q.push_back(8'($urandom_range(CH_LOW, CH_HIGH)));
        end
        if ($urandom_range(0, 3) == 0) begin
          rx_bytes_q.push_back(8'($urandom_range(CH_LOW, CH_HIGH)));
          rx_bytes_q.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
        end
        rx_bytes_q.push_back(CH_LF);
      end else if (c < 82) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          rx_bytes_q.push_back(8'($urandom_range(CH_LOW, CH_HIGH)));
        end
        rx_bytes_q.push_back(CH_LF);
      end else begin
        rx_bytes_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    do @(posedge clk_i);
    while (rx_bytes_q.size() > 0 || s_axis_tvalid || reply_q.size() > 0);
    repeat (100) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/scle_pkg.sv
sv/scle_front.sv
sv/scle_fifo.sv
sv/scle_back.sv
sv/serial_command_line_editor.sv
verif/serial_command_line_editor_tb.sv
